// ===== rtl/bmprle8_pkg.sv =====
package bmprle8_pkg;

    localparam int unsigned DIM_W   = 13;
    localparam int unsigned POS_W   = 2 * DIM_W;
    localparam int unsigned START_W = 24;
    localparam int unsigned LEN_W   = 25;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [1:0] CMD_PAL_WRITE = 2'd0;
    localparam logic [1:0] CMD_STREAM    = 2'd1;
    localparam logic [1:0] CMD_NEW_IMAGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0] ESC_END_LINE   = 8'd0;
    localparam logic [7:0] ESC_END_BITMAP = 8'd1;
    localparam logic [7:0] ESC_DELTA      = 8'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] pal_index;
        logic [7:0] pal_first;
        logic [7:0] pal_second;
        logic [7:0] pal_third;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [START_W-1:0] run_start;
        logic [LEN_W-1:0]   run_length;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic               image_done;
        logic               clipped;
    } t_out_word;

endpackage

// ===== rtl/bmp_rle8_run_decoder.sv =====
// channel   direction   handshake                 payload
// in        input       i_in_valid / o_in_stall   i_in_word   (bmprle8_pkg::t_in_word)
// out       output      o_out_valid / i_out_stall o_out_word  (bmprle8_pkg::t_out_word)
// cfg       input       i_cfg_we                  i_cfg_index, i_cfg_data
//
// palette writes and stream bytes that close no run leave the decoder idle;
// a byte that closes a run (index, absolute pixel, delta, end of bitmap) goes
// through S_AVAIL and S_EMIT; an end-of-line first runs the bit-serial remainder
// unit and S_FILL (one bit of pixel position per cycle, 26 bits)
// synchronous active-low reset clears decode state; palette is not cleared
// o_in_stall is high while a word is in work; a waiting output word only
// holds the emit step, the input side is free meanwhile
module bmp_rle8_run_decoder #(
    parameter int unsigned MAX_DIM         = 4096,
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  bmprle8_pkg::t_in_word                 i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output bmprle8_pkg::t_out_word                o_out_word,
    input  logic                                  i_cfg_we,
    input  logic [bmprle8_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bmprle8_pkg::DIM_W-1:0]         i_cfg_data
);

    localparam int unsigned DIM_W = bmprle8_pkg::DIM_W;
    localparam int unsigned POS_W = bmprle8_pkg::POS_W;
    localparam int unsigned DIM_CAP_I = (MAX_DIM > (2 ** DIM_W) - 1) ?
                                        (2 ** DIM_W) - 1 : MAX_DIM;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_CAP_I);
    localparam int unsigned PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(POS_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(POS_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FILL,
        S_AVAIL,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_INDEX,
        PH_ESCAPE,
        PH_DX,
        PH_DY,
        PH_ABS,
        PH_PAD
    } t_phase;

    t_state               r_state;
    t_phase               r_phase;
    logic                 r_finished;
    logic [7:0]           r_held_count;
    logic [7:0]           r_abs_left;
    logic                 r_pad_pending;
    logic [7:0]           r_delta_cols;
    logic [POS_W-1:0]     r_pos;
    logic [DIM_W-1:0]     r_width;
    logic [DIM_W-1:0]     r_height;
    logic [POS_W-1:0]     r_total;
    logic [POS_W-1:0]     r_len;
    logic [POS_W-1:0]     r_avail;
    logic                 r_done;
    logic                 r_pal_zero;
    logic [23:0]          r_pal_rd;
    logic [POS_W-1:0]     r_div_q;
    logic [DIM_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_div_cnt;
    logic                 r_out_valid;
    bmprle8_pkg::t_out_word r_out_word;
    logic [23:0]          r_palette [PALETTE_ENTRIES];

    logic                 w_in_acc;
    logic [7:0]           w_byte;
    logic                 w_byte_ok;
    logic                 w_use_byte;
    logic [PAL_AW-1:0]    w_rd_addr;
    logic [POS_W-1:0]     w_area;
    logic [POS_W-1:0]     w_delta_len;
    logic [DIM_W:0]       w_trial;
    logic [DIM_W:0]       w_trial_sub;
    logic [DIM_W-1:0]     w_rem_next;
    logic [7:0]           w_abs_next;
    logic                 w_clip;
    logic [POS_W-1:0]     w_len;
    logic                 w_out_free;
    logic                 w_emit;
    logic [DIM_W-1:0]     w_cfg_sat;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_byte     = i_in_word.data_byte;
    assign w_byte_ok  = ({1'b0, w_byte} < 9'(PALETTE_ENTRIES));
    assign w_use_byte = (r_phase == PH_INDEX) || (r_phase == PH_ABS);
    assign w_rd_addr  = w_use_byte ? w_byte[PAL_AW-1:0] : '0;

    assign w_area      = POS_W'(r_width) * POS_W'(r_height);
    assign w_delta_len = POS_W'(w_byte) * POS_W'(r_width) + POS_W'(r_delta_cols);

    // restoring remainder step
    assign w_trial     = {r_rem, r_div_q[POS_W-1]};
    assign w_trial_sub = w_trial - {1'b0, r_width};
    assign w_rem_next  = (w_trial >= {1'b0, r_width}) ? w_trial_sub[DIM_W-1:0]
                                                      : w_trial[DIM_W-1:0];

    assign w_abs_next = (r_abs_left != 8'd0) ? r_abs_left - 8'd1 : r_abs_left;

    assign w_clip = !r_done && (r_len > r_avail);
    assign w_len  = (r_done || w_clip) ? r_avail : r_len;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit = (r_state == S_EMIT) && w_out_free && (w_len != '0 || r_done);

    assign w_cfg_sat = (i_cfg_data == '0) ? DIM_W'(1) :
                       (i_cfg_data > DIM_CAP) ? DIM_CAP : i_cfg_data;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    function automatic logic w_byte_ok_idx();
        w_byte_ok_idx = ({1'b0, i_in_word.pal_index} < 9'(PALETTE_ENTRIES));
    endfunction

    // palette store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_word.cmd == bmprle8_pkg::CMD_PAL_WRITE && w_byte_ok_idx()) begin
            r_palette[i_in_word.pal_index[PAL_AW-1:0]] <=
                {i_in_word.pal_third, i_in_word.pal_second, i_in_word.pal_first};
        end
        if (w_in_acc) begin
            r_pal_rd <= r_palette[w_rd_addr];
        end
    end

    // configuration and image area
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bmprle8_pkg::CFG_IMAGE_WIDTH:  r_width  <= w_cfg_sat;
                bmprle8_pkg::CFG_IMAGE_HEIGHT: r_height <= w_cfg_sat;
                default: ;
            endcase
        end
        r_total <= w_area;
    end

    // decode sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_COUNT;
            r_finished    <= 1'b0;
            r_held_count  <= '0;
            r_abs_left    <= '0;
            r_pad_pending <= 1'b0;
            r_delta_cols  <= '0;
            r_pos         <= '0;
            r_done        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_pal_zero <= w_use_byte && !w_byte_ok;
                        case (i_in_word.cmd)
                            bmprle8_pkg::CMD_NEW_IMAGE: begin
                                r_phase       <= PH_COUNT;
                                r_held_count  <= '0;
                                r_abs_left    <= '0;
                                r_pad_pending <= 1'b0;
                                r_delta_cols  <= '0;
                                r_pos         <= '0;
                                r_finished    <= 1'b0;
                            end
                            bmprle8_pkg::CMD_STREAM: begin
                                if (!r_finished) begin
                                    unique case (r_phase)
                                        PH_COUNT: begin
                                            if (w_byte != 8'd0) begin
                                                r_held_count <= w_byte;
                                                r_phase      <= PH_INDEX;
                                            end else begin
                                                r_phase <= PH_ESCAPE;
                                            end
                                        end
                                        PH_INDEX: begin
                                            r_phase <= PH_COUNT;
                                            r_len   <= POS_W'(r_held_count);
                                            r_state <= S_AVAIL;
                                        end
                                        PH_ESCAPE: begin
                                            case (w_byte)
                                                bmprle8_pkg::ESC_END_LINE: begin
                                                    r_phase   <= PH_COUNT;
                                                    r_div_q   <= r_pos;
                                                    r_rem     <= '0;
                                                    r_div_cnt <= '0;
                                                    r_state   <= S_DIV;
                                                end
                                                bmprle8_pkg::ESC_END_BITMAP: begin
                                                    r_phase    <= PH_COUNT;
                                                    r_finished <= 1'b1;
                                                    r_done     <= 1'b1;
                                                    r_len      <= '0;
                                                    r_state    <= S_AVAIL;
                                                end
                                                bmprle8_pkg::ESC_DELTA: begin
                                                    r_phase <= PH_DX;
                                                end
                                                default: begin
                                                    r_abs_left    <= w_byte;
                                                    r_pad_pending <= w_byte[0];
                                                    r_phase       <= PH_ABS;
                                                end
                                            endcase
                                        end
                                        PH_DX: begin
                                            r_delta_cols <= w_byte;
                                            r_phase      <= PH_DY;
                                        end
                                        PH_DY: begin
                                            r_phase <= PH_COUNT;
                                            r_len   <= w_delta_len;
                                            r_state <= S_AVAIL;
                                        end
                                        PH_ABS: begin
                                            r_abs_left <= w_abs_next;
                                            if (w_abs_next == 8'd0) begin
                                                r_phase <= r_pad_pending ? PH_PAD : PH_COUNT;
                                            end
                                            r_len   <= POS_W'(1);
                                            r_state <= S_AVAIL;
                                        end
                                        PH_PAD: begin
                                            r_pad_pending <= 1'b0;
                                            r_phase       <= PH_COUNT;
                                        end
                                        default: begin
                                            r_phase <= PH_COUNT;
                                        end
                                    endcase
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem     <= w_rem_next;
                    r_div_q   <= {r_div_q[POS_W-2:0], 1'b0};
                    r_div_cnt <= r_div_cnt + CNT_W'(1);
                    if (r_div_cnt == CNT_LAST) begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_len   <= (r_rem == '0) ? '0 : POS_W'(r_width - r_rem);
                    r_state <= S_AVAIL;
                end
                S_AVAIL: begin
                    r_avail <= (r_total > r_pos) ? r_total - r_pos : '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b0;
                        if (w_len != '0 || r_done) begin
                            r_out_word.run_start  <= (w_len == '0) ? '0
                                : r_pos[bmprle8_pkg::START_W-1:0];
                            r_out_word.run_length <= w_len[bmprle8_pkg::LEN_W-1:0];
                            r_out_word.out_red    <= r_pal_zero ? 8'd0 : r_pal_rd[23:16];
                            r_out_word.out_green  <= r_pal_zero ? 8'd0 : r_pal_rd[15:8];
                            r_out_word.out_blue   <= r_pal_zero ? 8'd0 : r_pal_rd[7:0];
                            r_out_word.image_done <= r_done;
                            r_out_word.clipped    <= w_clip;
                            r_pos                 <= r_pos + w_len;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_nonzero_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.image_done) |-> (r_out_word.run_length != '0))
        else $error("empty run word without end of bitmap");

    a_clip_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && w_clip) |=> (r_pos == r_total))
        else $error("clipped run does not end at image end");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_width))
        else $error("remainder out of range");

    a_finished_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_word.cmd == bmprle8_pkg::CMD_STREAM && r_finished)
        |=> (r_state == S_IDLE))
        else $error("stream word after end of bitmap started work");

endmodule
